@@ rtl/amrwb_hc_pkg.sv @@
// Package: item types, status codes and frame size tables for the AMR-WB header check.
`default_nettype none
package amrwb_hc_pkg;

  // Input item
  typedef struct packed {
    logic       no_data;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] packet_length;
  } amrwb_hc_in_t;

  // Result item
  typedef struct packed {
    logic [3:0] status;
    logic [3:0] frame_kind;
    logic       good_quality;
    logic       more_frames;
    logic [3:0] requested_mode;
    logic       data_offset;
    logic [5:0] bytes_consumed;
  } amrwb_hc_out_t;

  // Status codes
  localparam logic [3:0] ST_OK_HDR    = 4'd0;
  localparam logic [3:0] ST_OK_NOHDR  = 4'd1;
  localparam logic [3:0] ST_BAD_MODE  = 4'd2;
  localparam logic [3:0] ST_CNG       = 4'd3;
  localparam logic [3:0] ST_EMPTY     = 4'd4;
  localparam logic [3:0] ST_BAD_TOC   = 4'd5;
  localparam logic [3:0] ST_BAD_SIZE  = 4'd6;
  localparam logic [3:0] ST_BAD_CMR   = 4'd7;
  localparam logic [3:0] ST_BW_EFF    = 4'd8;

  // ToC and CMR field constants
  localparam logic [7:0] PAD_MASK     = 8'h03;
  localparam logic [7:0] QUALITY_MASK = 8'h04;
  localparam logic [3:0] NO_REQUEST   = 4'hF;
  localparam logic [3:0] MAX_MODE     = 4'd8;
  localparam logic [3:0] SID_TYPE     = 4'd9;
  localparam logic [3:0] LOST_TYPE    = 4'd14;
  localparam logic [3:0] NODATA_TYPE  = 4'd15;
  localparam logic [9:0] BWE_OVERHEAD = 10'd17; // 10 header bits plus 7 for rounding up

  // Frame type is usable: speech, SID, lost or no data
  function automatic logic type_ok(input logic [3:0] t);
    return (t <= SID_TYPE) || (t == LOST_TYPE) || (t == NODATA_TYPE);
  endfunction

  // Octet-aligned speech frame size in bytes per frame type
  function automatic logic [5:0] octet_size(input logic [3:0] t);
    logic [5:0] s;
    unique case (t)
      4'd0:    s = 6'd18;
      4'd1:    s = 6'd24;
      4'd2:    s = 6'd33;
      4'd3:    s = 6'd37;
      4'd4:    s = 6'd41;
      4'd5:    s = 6'd47;
      4'd6:    s = 6'd51;
      4'd7:    s = 6'd59;
      4'd8:    s = 6'd61;
      4'd9:    s = 6'd6;
      4'd10:   s = 6'd6;
      4'd14:   s = 6'd1;
      4'd15:   s = 6'd1;
      default: s = 6'd0;
    endcase
    return s;
  endfunction

  // Core bits per frame type
  function automatic logic [8:0] core_bits(input logic [3:0] t);
    logic [8:0] b;
    unique case (t)
      4'd0:    b = 9'd132;
      4'd1:    b = 9'd177;
      4'd2:    b = 9'd253;
      4'd3:    b = 9'd285;
      4'd4:    b = 9'd317;
      4'd5:    b = 9'd365;
      4'd6:    b = 9'd397;
      4'd7:    b = 9'd461;
      4'd8:    b = 9'd477;
      4'd9:    b = 9'd40;
      4'd10:   b = 9'd40;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

  // Bandwidth-efficient packet size in bytes: bits plus overhead, rounded up
  function automatic logic [5:0] bwe_size(input logic [3:0] t);
    logic [9:0] sum;
    sum = {1'b0, core_bits(t)} + BWE_OVERHEAD;
    return sum[8:3];
  endfunction

endpackage
`default_nettype wire

@@ rtl/amrwb_payload_header_check_unit.sv @@
// Top level: three-stage pipelined AMR-WB single-frame payload header classifier.
// Each item passes the stage 1, stage 2 and output registers before its result shows on out_valid.
// Throughput: one item per cycle; busy is always low and the receiver cannot hold results off.
// Stage 1 looks up frame sizes, stage 2 compares lengths, stage 3 forms the result.
// Reset (rst_n low, synchronous) clears the stage valid bits; no result follows it.
`default_nettype none
module amrwb_payload_header_check_unit
  import amrwb_hc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire amrwb_hc_in_t  in_item,
  output logic               out_valid,
  output amrwb_hc_out_t      out_item
);

  // Outcome of the checks, worst to best
  localparam logic [2:0] V_BAD_CMR  = 3'd0;
  localparam logic [2:0] V_BAD_SIZE = 3'd1;
  localparam logic [2:0] V_BAD_TOC  = 3'd2;
  localparam logic [2:0] V_BAD_MODE = 3'd3;
  localparam logic [2:0] V_GOOD     = 3'd4;

  assign busy = 1'b0;

  // ---------------- Stage 1: ToC decode and table lookups ----------------
  logic       s1_valid_r;
  logic       s1_nd_r;
  logic [7:0] s1_b0_r, s1_b1_r, s1_len_r;
  logic       s1_t1ok_r, s1_t2ok_r, s1_bweok_r;
  logic [5:0] s1_size1_r, s1_size2_r, s1_bwsize_r;

  logic [3:0] bwe_type;
  logic [3:0] bwe_mode;
  assign bwe_type = {in_item.first_byte[2:0], in_item.second_byte[7]};
  assign bwe_mode = in_item.first_byte[7:4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start;
    end
    s1_nd_r     <= in_item.no_data;
    s1_b0_r     <= in_item.first_byte;
    s1_b1_r     <= in_item.second_byte;
    s1_len_r    <= in_item.packet_length;
    s1_t1ok_r   <= ((in_item.second_byte & PAD_MASK) == 8'h00)
                   && type_ok(in_item.second_byte[6:3]);
    s1_t2ok_r   <= ((in_item.first_byte & PAD_MASK) == 8'h00)
                   && type_ok(in_item.first_byte[6:3]);
    s1_size1_r  <= octet_size(in_item.second_byte[6:3]);
    s1_size2_r  <= octet_size(in_item.first_byte[6:3]);
    s1_bweok_r  <= ((bwe_mode <= MAX_MODE) || (bwe_mode == NO_REQUEST)) && type_ok(bwe_type);
    s1_bwsize_r <= bwe_size(bwe_type);
  end

  // ---------------- Stage 2: length compares and verdict ----------------
  logic [2:0] hdr_code;
  logic       hdr_size_ok, alt_ok, mode_bad, use_alt;
  logic [3:0] s1_mode;

  assign s1_mode     = s1_b0_r[7:4];
  assign hdr_size_ok = (s1_len_r == ({2'b00, s1_size1_r} + 8'd1));
  assign alt_ok      = s1_t2ok_r && (s1_len_r == {2'b00, s1_size2_r});
  assign mode_bad    = (s1_mode > MAX_MODE) && (s1_mode != NO_REQUEST);

  // Octet-aligned header checks, first failure wins
  always_comb begin
    priority if (!s1_t1ok_r) begin
      hdr_code = V_BAD_TOC;
    end else if (!hdr_size_ok) begin
      hdr_code = V_BAD_SIZE;
    end else if (s1_b0_r[3:0] != 4'h0) begin
      hdr_code = V_BAD_CMR;
    end else if (mode_bad) begin
      hdr_code = V_BAD_MODE;
    end else begin
      hdr_code = V_GOOD;
    end
  end

  // Header-less retry when the header path is not clean
  assign use_alt = (hdr_code != V_GOOD) && alt_ok;

  logic       s2_valid_r;
  logic       s2_nd_r, s2_empty_r, s2_bwe_r, s2_hdr_r;
  logic [2:0] s2_code_r;
  logic [7:0] s2_toc_r;
  logic [3:0] s2_mode_r;
  logic [5:0] s2_used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_nd_r    <= s1_nd_r;
    s2_empty_r <= (s1_len_r == 8'd0);
    s2_bwe_r   <= s1_bweok_r && (s1_len_r == {2'b00, s1_bwsize_r});
    s2_hdr_r   <= !use_alt;
    s2_code_r  <= use_alt ? V_GOOD : hdr_code;
    s2_toc_r   <= use_alt ? s1_b0_r : s1_b1_r;
    s2_mode_r  <= use_alt ? NO_REQUEST : s1_mode;
    s2_used_r  <= use_alt ? s1_size2_r : (s1_size1_r + 6'd1);
  end

  // ---------------- Stage 3: result formation ----------------
  amrwb_hc_out_t res;
  logic          rejected;

  assign rejected = (s2_code_r == V_BAD_TOC) || (s2_code_r == V_BAD_SIZE)
                    || (s2_code_r == V_BAD_CMR);

  always_comb begin
    res                = '0;
    res.requested_mode = NO_REQUEST;
    priority if (s2_nd_r) begin
      res.status     = ST_CNG;
      res.frame_kind = NODATA_TYPE;
    end else if (s2_empty_r) begin
      res.status = ST_EMPTY;
    end else if (rejected && s2_bwe_r) begin
      res.status = ST_BW_EFF;
    end else if (s2_code_r == V_BAD_TOC) begin
      res.status = ST_BAD_TOC;
    end else if (s2_code_r == V_BAD_SIZE) begin
      res.status = ST_BAD_SIZE;
    end else if (s2_code_r == V_BAD_CMR) begin
      res.status = ST_BAD_CMR;
    end else begin
      if (s2_code_r == V_BAD_MODE) begin
        res.status = ST_BAD_MODE;
      end else begin
        res.status = s2_hdr_r ? ST_OK_HDR : ST_OK_NOHDR;
      end
      res.frame_kind     = s2_toc_r[6:3];
      res.good_quality   = ((s2_toc_r & QUALITY_MASK) != 8'h00);
      res.more_frames    = s2_toc_r[7];
      res.requested_mode = s2_mode_r;
      res.data_offset    = s2_hdr_r;
      res.bytes_consumed = s2_used_r;
    end
  end

  logic          out_valid_r;
  amrwb_hc_out_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_valid_r;
    end
    out_item_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  // Every result traces back to an item that was accepted with start
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 3))
    else $error("result without matching item");

  // Rejections carry no frame information
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status >= ST_EMPTY) |->
      (out_item.frame_kind == 4'd0) && (out_item.bytes_consumed == 6'd0)
      && (out_item.requested_mode == NO_REQUEST) && !out_item.data_offset)
    else $error("rejected item carries frame fields");

  // Header-less acceptance reports no mode request and zero offset
  a_nohdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_OK_NOHDR) |->
      !out_item.data_offset && (out_item.requested_mode == NO_REQUEST))
    else $error("header-less item with header fields");
`endif

endmodule
`default_nettype wire
